>>> sv/sct_pkg.sv
// Shared types, constants and the Schmitt detector for the scope capture trigger unit.
// Used by the channel interfaces, the store, the control block and the top level.
package sct_pkg;

    localparam int DEPTH    = 512;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COUNT_W  = ADDR_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int TICK_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_LISSAJOUS    = 3'd0;
    localparam t_cfg_index CFG_DECIMATION   = 3'd1;
    localparam t_cfg_index CFG_HOLDOFF      = 3'd2;
    localparam t_cfg_index CFG_TRIGGER_LOW  = 3'd3;
    localparam t_cfg_index CFG_TRIGGER_HIGH = 3'd4;

    typedef enum logic [2:0] {
        LVL_UNKNOWN = 3'b001,
        LVL_LOW     = 3'b010,
        LVL_HIGH    = 3'b100
    } t_level;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        operation;
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic signed [SAMPLE_W-1:0] trig_sample;
        logic                       trig_connected;
        logic                       mode_button;
        logic [ADDR_W-1:0]          read_index;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] read_x;
        logic signed [SAMPLE_W-1:0] read_y;
        logic [COUNT_W-1:0]         write_position;
        logic                       waiting_for_trigger;
        logic                       external_mode;
        logic                       rearmed;
    } t_out_item;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } t_store_wr;

    typedef struct packed {
        t_level level;
        logic   rise;
    } t_schmitt_res;

    function automatic t_schmitt_res schmitt(
        input t_level                     st,
        input logic signed [SAMPLE_W-1:0] v,
        input logic signed [SAMPLE_W-1:0] lo,
        input logic signed [SAMPLE_W-1:0] hi
    );
        t_schmitt_res r;
        r.level = st;
        r.rise  = 1'b0;
        unique case (st)
            LVL_LOW: begin
                if (v >= hi) begin
                    r.level = LVL_HIGH;
                    r.rise  = 1'b1;
                end
            end
            LVL_HIGH: begin
                if (v <= lo) begin
                    r.level = LVL_LOW;
                end
            end
            default: begin
                if (v >= hi) begin
                    r.level = LVL_HIGH;
                end else if (v <= lo) begin
                    r.level = LVL_LOW;
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/sct_in_if.sv
// Input channel of the scope capture trigger unit: valid, ready and one input item.
// Depends on sct_pkg for the item type.
interface sct_in_if;
    logic              valid;
    logic              ready;
    sct_pkg::t_in_item payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

>>> sv/sct_out_if.sv
// Result channel of the scope capture trigger unit: valid, ready and one result item.
// Depends on sct_pkg for the item type.
interface sct_out_if;
    logic               valid;
    logic               ready;
    sct_pkg::t_out_item payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

>>> sv/sct_store.sv
// Capture store: one X/Y pair memory with a registered read port.
// A write landing on the same edge as a read of the same entry is forwarded.
// Depends on sct_pkg.
module sct_store (
    input  logic                                i_clk,
    input  sct_pkg::t_store_wr                  i_wr,
    input  logic                                i_rd_en,
    input  logic [sct_pkg::ADDR_W-1:0]          i_rd_addr,
    output logic signed [sct_pkg::SAMPLE_W-1:0] o_rd_x,
    output logic signed [sct_pkg::SAMPLE_W-1:0] o_rd_y
);

    logic [2*sct_pkg::SAMPLE_W-1:0] r_mem [sct_pkg::DEPTH];
    logic [2*sct_pkg::SAMPLE_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.x, i_wr.y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd <= {i_wr.x, i_wr.y};
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_x = $signed(r_rd[2*sct_pkg::SAMPLE_W-1:sct_pkg::SAMPLE_W]);
    assign o_rd_y = $signed(r_rd[sct_pkg::SAMPLE_W-1:0]);

endmodule

>>> sv/sct_ctrl.sv
// Capture control: configuration registers, decimation and wait counters, the trigger
// and button detectors, and the result for the item held in the input register.
// Depends on sct_pkg.
module sct_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  sct_pkg::t_cfg_index                 i_cfg_index,
    input  logic [sct_pkg::CFG_W-1:0]           i_cfg_data,
    input  sct_pkg::t_in_item                   i_item,
    input  logic                                i_commit,
    input  logic signed [sct_pkg::SAMPLE_W-1:0] i_rd_x,
    input  logic signed [sct_pkg::SAMPLE_W-1:0] i_rd_y,
    output sct_pkg::t_store_wr                  o_wr,
    output sct_pkg::t_out_item                  o_result
);

    logic                                r_lissajous;
    logic [sct_pkg::TICK_W-1:0]          r_period;
    logic [sct_pkg::TICK_W-1:0]          r_holdoff;
    logic signed [sct_pkg::SAMPLE_W-1:0] r_trig_low;
    logic signed [sct_pkg::SAMPLE_W-1:0] r_trig_high;

    logic [sct_pkg::COUNT_W-1:0] r_count, n_count;
    logic [sct_pkg::TICK_W-1:0]  r_tick, n_tick;
    sct_pkg::t_level             r_trig, n_trig;
    sct_pkg::t_level             r_btn, n_btn;
    logic                        r_ext, n_ext;

    logic                                store_now;
    logic                                rearm;
    logic [sct_pkg::TICK_W-1:0]          tick_inc;
    logic signed [sct_pkg::SAMPLE_W-1:0] gate;
    sct_pkg::t_level                     trig_from;
    sct_pkg::t_schmitt_res               btn_res;
    sct_pkg::t_schmitt_res               trig_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lissajous <= 1'b1;
            r_period    <= 16'd3;
            r_holdoff   <= 16'd4410;
            r_trig_low  <= 16'sd0;
            r_trig_high <= 16'sd2048;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sct_pkg::CFG_LISSAJOUS:    r_lissajous <= i_cfg_data[0];
                sct_pkg::CFG_DECIMATION:   r_period    <= i_cfg_data;
                sct_pkg::CFG_HOLDOFF:      r_holdoff   <= i_cfg_data;
                sct_pkg::CFG_TRIGGER_LOW:  r_trig_low  <= $signed(i_cfg_data);
                sct_pkg::CFG_TRIGGER_HIGH: r_trig_high <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_count   = r_count;
        n_tick    = r_tick;
        n_trig    = r_trig;
        n_btn     = r_btn;
        n_ext     = r_ext;
        store_now = 1'b0;
        rearm     = 1'b0;
        tick_inc  = r_tick;
        trig_from = r_trig;
        gate      = i_item.x_sample;
        btn_res   = sct_pkg::schmitt(r_btn,
                                     $signed({{(sct_pkg::SAMPLE_W-1){1'b0}}, i_item.mode_button}),
                                     16'sd0, 16'sd1);
        trig_res  = sct_pkg::schmitt(r_trig, gate, r_trig_low, r_trig_high);

        if (i_item.operation == sct_pkg::OP_TICK) begin
            n_btn = btn_res.level;
            if (btn_res.rise) begin
                n_ext = ~r_ext;
            end

            if (r_count < sct_pkg::COUNT_FULL) begin
                if (r_tick >= r_period) begin
                    store_now = 1'b1;
                    n_tick    = '0;
                    n_count   = r_count + 1'b1;
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end

            if (n_count == sct_pkg::COUNT_FULL) begin
                if (r_lissajous || (n_ext && !i_item.trig_connected)) begin
                    rearm = 1'b1;
                end else begin
                    trig_from = (n_tick == '0) ? sct_pkg::LVL_UNKNOWN : r_trig;
                    tick_inc  = (n_tick != sct_pkg::TICK_MAX) ? n_tick + 1'b1 : n_tick;
                    n_tick    = tick_inc;
                    gate      = n_ext ? i_item.trig_sample : i_item.x_sample;
                    trig_res  = sct_pkg::schmitt(trig_from, gate, r_trig_low, r_trig_high);
                    n_trig    = trig_res.level;
                    rearm     = trig_res.rise || (tick_inc >= r_holdoff);
                end
                if (rearm) begin
                    n_count = '0;
                    n_tick  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tick  <= '0;
            r_trig  <= sct_pkg::LVL_UNKNOWN;
            r_btn   <= sct_pkg::LVL_UNKNOWN;
            r_ext   <= 1'b0;
        end else if (i_commit) begin
            r_count <= n_count;
            r_tick  <= n_tick;
            r_trig  <= n_trig;
            r_btn   <= n_btn;
            r_ext   <= n_ext;
        end
    end

    always_comb begin
        o_wr.en   = store_now && i_commit;
        o_wr.addr = r_count[sct_pkg::ADDR_W-1:0];
        o_wr.x    = i_item.x_sample;
        o_wr.y    = i_item.y_sample;
    end

    always_comb begin
        if (i_item.operation == sct_pkg::OP_READ) begin
            o_result.read_x = i_rd_x;
            o_result.read_y = i_rd_y;
        end else begin
            o_result.read_x = '0;
            o_result.read_y = '0;
        end
        o_result.write_position      = n_count;
        o_result.waiting_for_trigger = (n_count == sct_pkg::COUNT_FULL);
        o_result.external_mode       = n_ext;
        o_result.rearmed             = rearm;
    end

endmodule

>>> sv/scope_capture_trigger_unit.sv
// Scope capture trigger unit: decimated two-channel capture with Schmitt re-arm logic.
// Each result is computed from the input register and loaded into the result register; a
// result not yet taken holds both. Throughput: one item per cycle while results are taken,
// set by the state update and the one read plus one write per cycle of the capture store.
// Reset clears counters, detectors and mode and loads the register defaults; the store
// contents stay undefined until written and no clearing pass is made.
module scope_capture_trigger_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  sct_pkg::t_cfg_index            i_cfg_index,
    input  logic [sct_pkg::CFG_W-1:0]      i_cfg_data,
    sct_in_if.sink                         i_in,
    sct_out_if.source                      o_out
);

    logic                                in_xfer;
    logic                                advance;
    logic                                r_item_valid;
    sct_pkg::t_in_item                   r_item;
    logic                                r_out_valid;
    sct_pkg::t_out_item                  r_out;
    sct_pkg::t_store_wr                  wr;
    sct_pkg::t_out_item                  result;
    logic signed [sct_pkg::SAMPLE_W-1:0] rd_x;
    logic signed [sct_pkg::SAMPLE_W-1:0] rd_y;

    assign advance     = r_item_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_item_valid || advance;
    assign in_xfer     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_xfer) begin
            r_item_valid <= 1'b1;
        end else if (advance) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in.payload;
        end
    end

    sct_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (in_xfer && (i_in.payload.operation == sct_pkg::OP_READ)),
        .i_rd_addr (i_in.payload.read_index),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y)
    );

    sct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (r_item),
        .i_commit    (advance),
        .i_rd_x      (rd_x),
        .i_rd_y      (rd_y),
        .o_wr        (wr),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

>>> test/testbench.sv
// Self-checking testbench for scope_capture_trigger_unit: directed ticks and reads, then
// randomised capture runs through fill, trigger wait and re-arm under several settings.
// Depends on sct_pkg, sct_in_if and sct_out_if; results are checked against a local predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int WORD_MAX    = 65535;
    localparam int SAMPLE_W    = sct_pkg::SAMPLE_W;
    localparam int ADDR_W      = sct_pkg::ADDR_W;
    localparam int COUNT_W     = sct_pkg::COUNT_W;
    localparam int CFG_W       = sct_pkg::CFG_W;
    localparam int DEPTH       = sct_pkg::DEPTH;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    sct_pkg::t_cfg_index cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    sct_in_if  sample_ch ();
    sct_out_if result_ch ();

    scope_capture_trigger_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch),
        .o_out      (result_ch)
    );

    always #6 i_clk = ~i_clk;

    // Predicted capture state and register copies.
    logic signed [SAMPLE_W-1:0] x_copy [DEPTH];
    logic signed [SAMPLE_W-1:0] y_copy [DEPTH];
    int              captured        = 0;
    int              tick_wait       = 0;
    int              entries_written = 0;
    int              rearm_total     = 0;
    sct_pkg::t_level trig_lvl        = sct_pkg::LVL_UNKNOWN;
    sct_pkg::t_level button_lvl      = sct_pkg::LVL_UNKNOWN;
    bit              external_on     = 1'b0;
    bit              lissajous_on    = 1'b1;
    int              decim_period    = 3;
    int              holdoff_ticks   = 4410;
    int              thr_low         = 0;
    int              thr_high        = 2048;

    sct_pkg::t_in_item  queued_samples [$];
    sct_pkg::t_out_item predicted_results [$];
    sct_pkg::t_in_item  offered_item;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches  = 0;
    int cycle_count = 0;
    bit signal_quiet = 1'b0;
    bit button_drive = 1'b0;

    function automatic sct_pkg::t_schmitt_res level_detect(sct_pkg::t_level lvl, int v,
                                                           int lo, int hi);
        sct_pkg::t_schmitt_res r;
        r.level = lvl;
        r.rise  = 1'b0;
        case (lvl)
            sct_pkg::LVL_LOW: begin
                if (v >= hi) begin
                    r.level = sct_pkg::LVL_HIGH;
                    r.rise  = 1'b1;
                end
            end
            sct_pkg::LVL_HIGH: begin
                if (v <= lo) begin
                    r.level = sct_pkg::LVL_LOW;
                end
            end
            default: begin
                if (v >= hi) begin
                    r.level = sct_pkg::LVL_HIGH;
                end else if (v <= lo) begin
                    r.level = sct_pkg::LVL_LOW;
                end
            end
        endcase
        return r;
    endfunction

    function automatic sct_pkg::t_out_item capture_step(sct_pkg::t_in_item it);
        sct_pkg::t_out_item    res;
        sct_pkg::t_schmitt_res det;
        int                    gate;
        bit                    rearm;
        res   = '0;
        rearm = 1'b0;
        if (it.operation == sct_pkg::OP_READ) begin
            res.read_x = x_copy[it.read_index];
            res.read_y = y_copy[it.read_index];
        end else begin
            det = level_detect(button_lvl, int'(it.mode_button), 0, 1);
            button_lvl = det.level;
            if (det.rise) begin
                external_on = !external_on;
            end
            if (captured < DEPTH) begin
                if (tick_wait >= decim_period) begin
                    tick_wait = 0;
                    x_copy[captured] = it.x_sample;
                    y_copy[captured] = it.y_sample;
                    captured++;
                    if (captured > entries_written) begin
                        entries_written = captured;
                    end
                end else begin
                    tick_wait++;
                end
            end
            if (captured >= DEPTH) begin
                if (lissajous_on || (external_on && !it.trig_connected)) begin
                    rearm = 1'b1;
                end else begin
                    // The detector starts afresh on the tick that fills the store.
                    if (tick_wait == 0) begin
                        trig_lvl = sct_pkg::LVL_UNKNOWN;
                    end
                    if (tick_wait < WORD_MAX) begin
                        tick_wait++;
                    end
                    gate = external_on ? int'(it.trig_sample) : int'(it.x_sample);
                    det = level_detect(trig_lvl, gate, thr_low, thr_high);
                    trig_lvl = det.level;
                    rearm = det.rise || (tick_wait >= holdoff_ticks);
                end
                if (rearm) begin
                    captured  = 0;
                    tick_wait = 0;
                    rearm_total++;
                end
            end
        end
        res.write_position      = COUNT_W'(captured);
        res.waiting_for_trigger = (captured >= DEPTH);
        res.external_mode       = external_on;
        res.rearmed             = rearm;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int lo, int hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (signal_quiet && (lo + 1 < hi)) begin
            return SAMPLE_W'(lo + 1 + $urandom_range(0, hi - lo - 2));
        end else if (roll < 25) begin
            return SAMPLE_W'(lo - $urandom_range(0, lo + 32768));
        end else if (roll < 50) begin
            return SAMPLE_W'(hi + $urandom_range(0, 32767 - hi));
        end else if (roll < 60) begin
            return roll[0] ? 16'sh8000 : 16'sh7fff;
        end else if (roll < 70) begin
            return SAMPLE_W'((roll[0] ? lo : hi) + $urandom_range(0, 2) - 1);
        end
        return SAMPLE_W'($urandom);
    endfunction

    function automatic sct_pkg::t_in_item draw_capture_item();
        sct_pkg::t_in_item it;
        it = '0;
        if ($urandom_range(0, 49) == 0) begin
            signal_quiet = !signal_quiet;
        end
        if (entries_written > 0 && $urandom_range(0, 99) < 8) begin
            it.operation   = sct_pkg::OP_READ;
            it.read_index  = (entries_written >= DEPTH)
                             ? ADDR_W'($urandom_range(0, DEPTH - 1))
                             : ADDR_W'($urandom_range(0, entries_written - 1));
            it.x_sample    = SAMPLE_W'($urandom);
            it.y_sample    = SAMPLE_W'($urandom);
            it.trig_sample = SAMPLE_W'($urandom);
            it.trig_connected = 1'($urandom_range(0, 1));
            it.mode_button    = 1'($urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 29) == 0) begin
                button_drive = !button_drive;
            end
            it.operation      = sct_pkg::OP_TICK;
            it.x_sample       = pick_sample(thr_low, thr_high);
            it.y_sample       = SAMPLE_W'($urandom);
            it.trig_sample    = pick_sample(thr_low, thr_high);
            it.trig_connected = ($urandom_range(0, 9) != 0);
            it.mode_button    = button_drive;
            it.read_index     = ADDR_W'($urandom);
        end
        return it;
    endfunction

    task automatic queue_tick(int x, int y, int trig, bit connected, bit button);
        sct_pkg::t_in_item it;
        it = '0;
        it.operation      = sct_pkg::OP_TICK;
        it.x_sample       = SAMPLE_W'(x);
        it.y_sample       = SAMPLE_W'(y);
        it.trig_sample    = SAMPLE_W'(trig);
        it.trig_connected = connected;
        it.mode_button    = button;
        queued_samples.push_back(it);
    endtask

    task automatic queue_read(int index);
        sct_pkg::t_in_item it;
        it = '0;
        it.operation   = sct_pkg::OP_READ;
        it.read_index  = ADDR_W'(index);
        it.x_sample    = SAMPLE_W'($urandom);
        it.y_sample    = SAMPLE_W'($urandom);
        it.mode_button = 1'b1;
        queued_samples.push_back(it);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (queued_samples.size() != 0 || sample_ch.valid
                   || predicted_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(sct_pkg::t_cfg_index idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            sct_pkg::CFG_LISSAJOUS:    lissajous_on  = data[0];
            sct_pkg::CFG_DECIMATION:   decim_period  = int'(data);
            sct_pkg::CFG_HOLDOFF:      holdoff_ticks = int'(data);
            sct_pkg::CFG_TRIGGER_LOW:  thr_low       = int'($signed(data));
            sct_pkg::CFG_TRIGGER_HIGH: thr_high      = int'($signed(data));
            default: ;
        endcase
    endtask

    task automatic configure(bit lissajous, int decimation, int holdoff, int lo, int hi);
        wait_drained();
        write_register(sct_pkg::CFG_LISSAJOUS, CFG_W'(lissajous));
        write_register(sct_pkg::CFG_DECIMATION, CFG_W'(decimation));
        write_register(sct_pkg::CFG_HOLDOFF, CFG_W'(holdoff));
        write_register(sct_pkg::CFG_TRIGGER_LOW, CFG_W'(lo));
        write_register(sct_pkg::CFG_TRIGGER_HIGH, CFG_W'(hi));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int rearms_wanted, int trailing_items);
        int start_rearms;
        int left;
        start_rearms = rearm_total;
        left         = trailing_items;
        while (left > 0) begin
            @(negedge i_clk);
            if (queued_samples.size() < 4) begin
                queued_samples.push_back(draw_capture_item());
                if (rearm_total - start_rearms >= rearms_wanted) begin
                    left--;
                end
            end
        end
    endtask

    task automatic check_field(string label, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                predicted_results.push_back(capture_step(offered_item));
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (queued_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered_item = queued_samples.pop_front();
                    sample_ch.payload <= offered_item;
                    sample_ch.valid   <= 1'b1;
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        sct_pkg::t_out_item want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %p",
                             $time, result_ch.payload);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("read_x", want.read_x, result_ch.payload.read_x);
                    check_field("read_y", want.read_y, result_ch.payload.read_y);
                    check_field("write_position", want.write_position,
                                result_ch.payload.write_position);
                    check_field("waiting_for_trigger", want.waiting_for_trigger,
                                result_ch.payload.waiting_for_trigger);
                    check_field("external_mode", want.external_mode,
                                result_ch.payload.external_mode);
                    check_field("rearmed", want.rearmed, result_ch.payload.rearmed);
                end
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        sample_ch.valid   = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready   = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = sct_pkg::CFG_LISSAJOUS;
        cfg_data          = '0;
        i_rst_n           = 1'b0;
        send_idle_pct     = 27;
        recv_idle_pct     = 73;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: extremes of the samples, button edges and reads that
        // must leave the button detector untouched.
        queue_tick(-32768, 32767, -32768, 1'b0, 1'b0);
        queue_tick(0, 0, 32767, 1'b1, 1'b1);
        queue_tick(1, -1, 0, 1'b1, 1'b1);
        queue_tick(32767, -32768, 32767, 1'b0, 1'b0);
        queue_read(0);
        queue_tick(-32768, 32767, -32768, 1'b1, 1'b1);
        queue_tick(0, 0, 0, 1'b0, 1'b1);
        queue_tick(0, 0, 0, 1'b0, 1'b0);
        queue_tick(-32768, 32767, 0, 1'b1, 1'b0);
        queue_read(1);
        queue_read(0);

        configure(1'b1, 0, 4410, 0, 2048);
        queue_tick(21845, -21846, 32767, 1'b1, 1'b0);
        queue_tick(-21846, 21845, -32768, 1'b1, 1'b0);
        queue_tick(32767, 0, 2048, 1'b0, 1'b0);
        queue_tick(-1, -32768, 0, 1'b1, 1'b0);
        queue_tick(0, -1, -1, 1'b1, 1'b0);
        queue_read(6);
        queue_read(2);
        queue_read(5);
        queue_read(3);

        configure(1'b0, 0, 40, -1024, 1024);
        run_phase(1, 60);

        send_idle_pct = 73;
        recv_idle_pct = 27;
        configure(1'b0, 65535, 65535, -32768, 32767);
        run_phase(0, 24);
        configure(1'b0, 0, 0, 300, -300);
        run_phase(0, 150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(1'b1, 0, 1, 0, 2048);
        run_phase(0, 80);
        configure(1'b0, 2, 5, -2048, 0);
        run_phase(0, 40);

        wait_drained();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
